// ----- design/bdq_pkg.sv -----
// Package for the bounded deque: operation and status codes and the
// control struct broadcast to every storage cell. Depends on nothing.
package bdq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } bdq_op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bdq_status_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] CapReset = 5'd16;

  typedef struct packed {
    logic shift_back;
    logic shift_front;
    logic write_tail;
  } bdq_ctrl_t;

endpackage

// ----- design/bdq_if.sv -----
// Request and result channel interfaces of the bounded deque.
// Both carry valid, ready and the payload; they depend on nothing.
interface bdq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink (input valid, input operation, input push_value, output ready);
endinterface

interface bdq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         entry_count;
  logic               is_empty;
  logic               is_full;
  logic [1:0]         status;

  modport source (output valid, output front_value, output back_value, output entry_count,
                  output is_empty, output is_full, output status, input ready);
  modport sink (input valid, input front_value, input back_value, input entry_count,
                input is_empty, input is_full, input status, output ready);
endinterface

// ----- design/bdq_cell.sv -----
// One storage cell of the deque chain: holds one word and takes it from a
// neighbour or the request. Depends on bdq_pkg.
module bdq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                      clk_i,
  input  bdq_pkg::bdq_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic signed [31:0]        push_value_i,
  input  logic signed [31:0]        prev_data_i,
  input  logic signed [31:0]        next_data_i,
  output logic signed [31:0]        data_o,
  output logic signed [31:0]        back_tap_o
);
  import bdq_pkg::*;

  localparam logic [CNT_W-1:0] Idx   = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IdxP1 = CNT_W'(INDEX + 1);

  logic signed [31:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_back) begin
      data_d = prev_data_i;
    end else if (ctrl_i.shift_front) begin
      data_d = next_data_i;
    end else if (ctrl_i.write_tail && (count_i == Idx)) begin
      data_d = push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign back_tap_o = (count_i == IdxP1) ? data_q : '0;

endmodule

// ----- design/bounded_deque.sv -----
// Bounded double-ended queue of signed 32-bit words held in a chain of DEPTH cells.
// Depends on bdq_pkg, bdq_if and bdq_cell.
//
// The front word always sits in the first cell; a push or pop at the front shifts
// the whole chain by one place, while a push at the back writes the cell at the
// current count and a pop at the back only lowers the count. Requests are taken one
// at a time: the chain and the count update at acceptance, and the result register
// loads from the chain in the following cycle, the back word being picked from the
// cell whose index is one below the count.
module bounded_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  bdq_req_if.sink     req_i,
  bdq_rsp_if.source   rsp_o
);
  import bdq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;

  logic [CountW-1:0]   cap_q;
  logic [CntW-1:0]     count_d, count_q;
  bdq_status_e         status_d, status_q;
  logic                pend_q;
  logic                rsp_valid_d, rsp_valid_q;
  logic signed [31:0]  front_q, back_q;
  logic [CountW-1:0]   entry_q;
  logic                empty_q, full_q;

  bdq_ctrl_t           ctrl;
  logic                req_fire;
  logic [CmpW-1:0]     cap_ext, eff_cap, count_ext;
  logic                is_full, is_empty;
  logic signed [31:0]  cell_data [DEPTH];
  logic signed [31:0]  back_tap [DEPTH];
  logic signed [31:0]  back_word;

  assign req_i.ready = !pend_q && (!rsp_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign cap_ext   = CmpW'(cap_q);
  assign count_ext = CmpW'(count_q);
  assign eff_cap   = (cap_q == '0) ? CmpW'(1) :
                     ((cap_ext > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cap_ext);
  assign is_full   = count_ext >= eff_cap;
  assign is_empty  = count_q == '0;

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = status_q;
    if (req_fire) begin
      status_d = ST_DONE;
      unique case (bdq_op_e'(req_i.operation))
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.shift_back = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.write_tail = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.shift_front = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_data, next_data;
    if (i == 0) begin : g_first
      assign prev_data = req_i.push_value;
    end else begin : g_mid
      assign prev_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    bdq_cell #(
      .INDEX (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .push_value_i (req_i.push_value),
      .prev_data_i  (prev_data),
      .next_data_i  (next_data),
      .data_o       (cell_data[i]),
      .back_tap_o   (back_tap[i])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | back_tap[i];
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (pend_q) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      status_q    <= ST_DONE;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      status_q    <= status_d;
      pend_q      <= req_fire;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      front_q <= is_empty ? '0 : cell_data[0];
      back_q  <= is_empty ? '0 : back_word;
      entry_q <= CountW'(count_q);
      empty_q <= is_empty;
      full_q  <= is_full;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.front_value = front_q;
  assign rsp_o.back_value  = back_q;
  assign rsp_o.entry_count = entry_q;
  assign rsp_o.is_empty    = empty_q;
  assign rsp_o.is_full     = full_q;
  assign rsp_o.status      = status_q;

endmodule

// ----- bench/bounded_deque_test.sv -----
// Self-checking testbench for the bounded deque: request and result channels,
// capacity register, random idling and a long receiver hold-off.
// Depends on bdq_pkg, bdq_if and the bounded_deque top level.
module bounded_deque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int Depth       = 16;
  localparam int PtrW        = $clog2(Depth);
  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 12;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 10;

  localparam logic [2:0] OpReservedA = 3'd5;
  localparam logic [2:0] OpReservedB = 3'd6;
  localparam logic [2:0] OpReservedC = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
  } deque_request_t;

  typedef struct packed {
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic [4:0]         count;
    logic               empty;
    logic               full;
    bdq_status_e        status;
  } deque_view_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [4:0] cfg_wdata_i;

  bdq_req_if deque_req ();
  bdq_rsp_if deque_rsp ();

  bounded_deque #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (deque_req),
    .rsp_o      (deque_rsp)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  logic signed [31:0] ring [Depth];
  logic [PtrW-1:0]    head;
  logic [PtrW-1:0]    tail;
  logic [4:0]         count;
  logic [4:0]         capacity;

  deque_request_t pending_requests[$];
  deque_view_t    expected_views[$];
  deque_request_t offered;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int failures = 0;
  int accepted = 0;
  int checked = 0;
  int settings_used = 0;
  int pushes_rejected = 0;
  int pops_rejected = 0;

  function automatic deque_view_t deque_apply(input deque_request_t r);
    deque_view_t res;
    logic [4:0]  limit;
    limit = (capacity == 5'd0) ? 5'd1 : ((capacity > Depth) ? 5'(Depth) : capacity);
    res.status = ST_DONE;
    case (r.op)
      OP_PUSH_FRONT: begin
        if (count >= limit) begin
          res.status = ST_FULL;
        end else begin
          head = head - 1'b1;
          ring[head] = r.value;
          count = count + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count >= limit) begin
          res.status = ST_FULL;
        end else begin
          ring[tail] = r.value;
          tail = tail + 1'b1;
          count = count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count == 5'd0) begin
          res.status = ST_EMPTY;
        end else begin
          head = head + 1'b1;
          count = count - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count == 5'd0) begin
          res.status = ST_EMPTY;
        end else begin
          tail = tail - 1'b1;
          count = count - 1'b1;
        end
      end
      OP_CLEAR: begin
        head = '0;
        tail = '0;
        count = '0;
      end
      default: begin
      end
    endcase
    if (res.status == ST_FULL) pushes_rejected++;
    if (res.status == ST_EMPTY) pops_rejected++;
    res.count = count;
    res.empty = (count == 5'd0);
    res.full  = (count >= limit);
    res.front = res.empty ? '0 : ring[head];
    res.back  = res.empty ? '0 : ring[tail - 1'b1];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deque_req.valid <= 1'b0;
      deque_req.operation <= '0;
      deque_req.push_value <= '0;
    end else begin
      if (deque_req.valid && deque_req.ready) begin
        expected_views.push_back(deque_apply(offered));
        accepted++;
      end
      if (!deque_req.valid || deque_req.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_requests.pop_front();
          deque_req.valid <= 1'b1;
          deque_req.operation <= offered.op;
          deque_req.push_value <= offered.value;
        end else begin
          deque_req.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deque_rsp.ready <= 1'b0;
    end else begin
      if (deque_rsp.valid && deque_rsp.ready) begin
        deque_view_t seen;
        deque_view_t want;
        seen.front  = deque_rsp.front_value;
        seen.back   = deque_rsp.back_value;
        seen.count  = deque_rsp.entry_count;
        seen.empty  = deque_rsp.is_empty;
        seen.full   = deque_rsp.is_full;
        seen.status = bdq_status_e'(deque_rsp.status);
        if (expected_views.size() == 0) begin
          if (failures < ReportLimit) begin
            $display("%0t: result with no request outstanding: front %0d back %0d count %0d",
                     $realtime, seen.front, seen.back, seen.count);
          end
          failures++;
        end else begin
          want = expected_views.pop_front();
          checked++;
          if (seen !== want) begin
            if (failures < ReportLimit) begin
              $display("%0t: mismatch on result %0d", $realtime, checked);
              $display("  expected front %0d back %0d count %0d empty %0b full %0b status %0d",
                       want.front, want.back, want.count, want.empty, want.full, want.status);
              $display("  actual   front %0d back %0d count %0d empty %0b full %0b status %0d",
                       seen.front, seen.back, seen.count, seen.empty, seen.full, seen.status);
            end
            failures++;
          end
        end
      end
      deque_rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[bounded_deque] ERROR");
      $finish;
    end
  end

  task automatic add_request(input logic [2:0] op, input logic [31:0] value);
    deque_request_t r;
    r.op = op;
    r.value = value;
    pending_requests.push_back(r);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_random_requests(input int n);
    bit filling;
    int burst;
    int roll;
    filling = 1'b1;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(8, 40);
        filling = 1'($urandom_range(1));
      end
      burst--;
      roll = $urandom_range(99);
      if (roll < 3) begin
        add_request(3'($urandom_range(OpReservedA, OpReservedC)), pick_word());
      end else if (roll < 5) begin
        add_request(OP_CLEAR, pick_word());
      end else if ((roll < 75) == filling) begin
        add_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
      end else begin
        add_request($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || deque_req.valid || expected_views.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [4:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    capacity = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic run_random(input logic [4:0] cap, input int send_pct, input int recv_pct,
                            input int n);
    set_capacity(cap);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random_requests(n);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    deque_req.valid = 1'b0;
    deque_req.operation = '0;
    deque_req.push_value = '0;
    deque_rsp.ready = 1'b0;
    head = '0;
    tail = '0;
    count = '0;
    capacity = CapReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_request(OP_POP_FRONT, 32'h1234_5678);
    add_request(OP_POP_BACK, 32'h8765_4321);
    add_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    add_request(OP_PUSH_BACK, 32'h8000_0000);
    add_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    add_request(OP_PUSH_BACK, 32'h0000_0000);
    add_request(OpReservedA, 32'hAAAA_AAAA);
    add_request(OpReservedB, 32'h5555_5555);
    add_request(OpReservedC, 32'hFFFF_FFFF);
    add_request(OP_POP_BACK, 32'h0);
    add_request(OP_POP_FRONT, 32'h0);
    wait_drained();

    set_capacity(5'd1);
    add_request(OP_PUSH_BACK, 32'h0F0F_0F0F);
    add_request(OP_POP_FRONT, 32'h0);
    add_request(OP_PUSH_FRONT, 32'hF0F0_F0F0);
    add_request(OP_POP_BACK, 32'h0);
    add_request(OP_PUSH_BACK, 32'h0000_0001);
    wait_drained();

    set_capacity(5'd0);
    add_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    add_request(OP_CLEAR, 32'hFFFF_FFFF);
    add_request(OP_PUSH_FRONT, 32'h8000_0001);
    add_request(OP_PUSH_BACK, 32'h7FFF_FFFE);
    add_request(OP_CLEAR, 32'h0);
    wait_drained();

    run_random(5'd16, 0, 0, 250);
    run_random(5'd5, 51, 0, 250);
    run_random(5'd31, 0, 51, 250);
    run_random(5'd1, 30, 30, 200);

    set_capacity(5'd16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 80; i++) begin
      add_request($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    end
    wait_drained();

    run_random(5'd9, 30, 30, 250);
    run_random(5'd2, 0, 0, 60);

    $display("Ran %0d requests through %0d capacity settings, %0d results checked.",
             accepted, settings_used, checked);
    $display("Rejected pushes: %0d, rejected pops: %0d, failures: %0d.",
             pushes_rejected, pops_rejected, failures);
    if (failures == 0 && expected_views.size() == 0) begin
      $display("[bounded_deque] OK");
    end else begin
      $display("[bounded_deque] ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_cell.sv
design/bounded_deque.sv
bench/bounded_deque_test.sv
